// File: rtl/tkm_pkg.sv
package tkm_pkg;

  localparam int STREAMS_DEF = 16;

  // Stream id carried inside the chain; wide enough for the largest row
  localparam int SID_W      = 8;
  localparam int SIDX_W     = 4;
  localparam int TIME_W     = 64;
  localparam int EVENT_W    = 32;
  localparam int NODE_W     = 16;
  localparam int WRAP_W     = 16;
  localparam int OP_W       = 2;
  localparam int STAT_W     = 2;
  localparam int CFG_IDX_W  = 4;
  localparam int CFG_DATA_W = 32;

  localparam logic [WRAP_W-1:0] WRAP_MAX = '1;

  typedef enum logic [OP_W-1:0] {
    OP_PUSH   = 2'd0,
    OP_SELECT = 2'd1,
    OP_CLOSE  = 2'd2,
    OP_NOP    = 2'd3
  } op_t;

  typedef enum logic [STAT_W-1:0] {
    ST_ACCEPTED = 2'd0,
    ST_GIVEN    = 2'd1,
    ST_WAITING  = 2'd2,
    ST_NONE     = 2'd3
  } status_t;

  localparam logic [CFG_IDX_W-1:0] REG_ADJUST    = 4'd0;
  localparam logic [CFG_IDX_W-1:0] REG_INIT_CODE = 4'd1;

  // Broadcast to every cell; the cell whose id matches sid acts on it
  typedef struct packed {
    logic               push;
    logic               close;
    logic               take;
    logic [SID_W-1:0]   sid;
    logic [TIME_W-1:0]  rec_time;
    logic [EVENT_W-1:0] rec_event;
    logic [NODE_W-1:0]  rec_node;
    logic [EVENT_W-1:0] init_code;
  } cmd_t;

  // Best-so-far candidate handed from cell to cell behind the scan token
  typedef struct packed {
    logic               tok;
    logic               found;
    logic               pend;
    logic [SID_W-1:0]   sid;
    logic [WRAP_W-1:0]  wrap;
    logic [TIME_W-1:0]  rec_time;
    logic [EVENT_W-1:0] rec_event;
    logic [NODE_W-1:0]  rec_node;
  } cand_t;

endpackage

// File: rtl/tkm_cell.sv
module tkm_cell #(
  parameter int ID = 0
) (
  input  logic           clk,
  input  logic           rst_n,
  input  tkm_pkg::cmd_t  cmd,
  input  tkm_pkg::cand_t cand_in,
  output tkm_pkg::cand_t cand_out
);

  logic [tkm_pkg::TIME_W-1:0]  head_time_r;
  logic [tkm_pkg::EVENT_W-1:0] head_event_r;
  logic [tkm_pkg::NODE_W-1:0]  head_node_r;
  logic [tkm_pkg::NODE_W-1:0]  stream_node_r;
  logic                        known_r, known_nxt;
  logic [tkm_pkg::WRAP_W-1:0]  wrap_r, wrap_nxt;
  logic                        active_r, active_nxt;
  logic                        started_r, started_nxt;
  logic                        refill_r, refill_nxt;
  tkm_pkg::cand_t              cand_r, cand_nxt;

  logic hit;
  logic load;
  logic first;
  logic first_init;
  logic better;

  assign hit        = (cmd.sid == tkm_pkg::SID_W'(ID));
  assign first      = hit && cmd.push && !started_r;
  assign load       = hit && cmd.push && (!started_r || active_r);
  assign first_init = first && (cmd.rec_event == cmd.init_code);

  always_comb begin
    known_nxt   = known_r;
    wrap_nxt    = wrap_r;
    active_nxt  = active_r;
    started_nxt = started_r;
    refill_nxt  = refill_r;
    if (first) begin
      started_nxt = 1'b1;
      active_nxt  = 1'b1;
      refill_nxt  = 1'b0;
      wrap_nxt    = '0;
      known_nxt   = first_init;
    end else if (load) begin
      if (cmd.rec_time < head_time_r && wrap_r != tkm_pkg::WRAP_MAX) begin
        wrap_nxt = wrap_r + 1'b1;
      end
      refill_nxt = 1'b0;
    end else if (hit && cmd.close) begin
      started_nxt = 1'b1;
      active_nxt  = 1'b0;
      refill_nxt  = 1'b0;
    end else if (hit && cmd.take) begin
      refill_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      known_r   <= 1'b0;
      wrap_r    <= '0;
      active_r  <= 1'b0;
      started_r <= 1'b0;
      refill_r  <= 1'b0;
    end else begin
      known_r   <= known_nxt;
      wrap_r    <= wrap_nxt;
      active_r  <= active_nxt;
      started_r <= started_nxt;
      refill_r  <= refill_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      head_time_r  <= cmd.rec_time;
      head_event_r <= cmd.rec_event;
      head_node_r  <= cmd.rec_node;
    end
    if (first_init) begin
      stream_node_r <= cmd.rec_node;
    end
  end

  // fewest wraps first, then earliest time; an upstream tie keeps its lower index
  assign better = !cand_in.found || (wrap_r < cand_in.wrap) ||
                  (wrap_r == cand_in.wrap && head_time_r < cand_in.rec_time);

  always_comb begin
    cand_nxt = cand_in;
    if (cand_in.tok && active_r) begin
      if (refill_r) begin
        cand_nxt.pend = 1'b1;
      end else if (better) begin
        cand_nxt.found     = 1'b1;
        cand_nxt.sid       = tkm_pkg::SID_W'(ID);
        cand_nxt.wrap      = wrap_r;
        cand_nxt.rec_time  = head_time_r;
        cand_nxt.rec_event = head_event_r;
        cand_nxt.rec_node  = known_r ? stream_node_r : head_node_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cand_r <= '0;
    end else begin
      cand_r <= cand_nxt;
    end
  end

  assign cand_out = cand_r;

endmodule

// File: rtl/timestamp_kway_stream_merger_top.sv
// Channel | Direction | Handshake              | Payload
// in      | input     | in_valid / in_ready    | op, stream_index, rec_time/event/node
// out     | output    | out_valid / out_ready  | status, stream, time, event, node, wraps
// cfg     | input     | cfg_valid / cfg_ready  | cfg_index, cfg_data
//
// Push, close and no-op transactions write their result to the output register directly;
// a select waits for the scan token to walk the row of cells one stream per cycle.
// One transaction in flight at a time; in_ready is low during a scan and while
// a finished result sits unclaimed in the output register.
// Reset (rst_n low, synchronous) clears all stream flags, wrap counts, the base
// time and the configuration registers; cfg_ready is always high.
module timestamp_kway_stream_merger_top #(
  parameter int STREAMS = tkm_pkg::STREAMS_DEF
) (
  input  logic                             clk,
  input  logic                             rst_n,

  input  logic                             in_valid,
  output logic                             in_ready,
  input  logic [tkm_pkg::OP_W-1:0]         in_op,
  input  logic [tkm_pkg::SIDX_W-1:0]       in_stream_index,
  input  logic [tkm_pkg::TIME_W-1:0]       in_rec_time,
  input  logic [tkm_pkg::EVENT_W-1:0]      in_rec_event,
  input  logic [tkm_pkg::NODE_W-1:0]       in_rec_node,

  output logic                             out_valid,
  input  logic                             out_ready,
  output logic [tkm_pkg::STAT_W-1:0]       out_status,
  output logic [tkm_pkg::SIDX_W-1:0]       out_stream,
  output logic [tkm_pkg::TIME_W-1:0]       out_time,
  output logic [tkm_pkg::EVENT_W-1:0]      out_event,
  output logic [tkm_pkg::NODE_W-1:0]       out_node,
  output logic [tkm_pkg::WRAP_W-1:0]       out_wraps,

  input  logic                             cfg_valid,
  output logic                             cfg_ready,
  input  logic [tkm_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [tkm_pkg::CFG_DATA_W-1:0]   cfg_data
);

  typedef enum logic [1:0] {
    S_IDLE = 2'b01,
    S_SCAN = 2'b10
  } state_t;

  state_t state_r, state_nxt;

  logic                         adjust_r;
  logic [tkm_pkg::EVENT_W-1:0]  init_code_r;
  logic [tkm_pkg::TIME_W-1:0]   base_time_r;
  logic                         base_taken_r;

  logic                         out_valid_r;
  tkm_pkg::status_t             status_r;
  logic [tkm_pkg::SIDX_W-1:0]   stream_r;
  logic [tkm_pkg::TIME_W-1:0]   time_r;
  logic [tkm_pkg::EVENT_W-1:0]  event_r;
  logic [tkm_pkg::NODE_W-1:0]   node_r;
  logic [tkm_pkg::WRAP_W-1:0]   wraps_r;

  tkm_pkg::cmd_t                cmd;
  tkm_pkg::cand_t               chain [STREAMS+1];
  tkm_pkg::cand_t               last;
  logic [STREAMS:0]             tok_vec;

  tkm_pkg::op_t                 op;
  logic                         in_acc;
  logic                         idx_ok;
  logic                         scan_done;
  logic                         give;
  logic [tkm_pkg::TIME_W-1:0]   base_sel;
  logic [tkm_pkg::TIME_W-1:0]   time_adj;

  assign op        = tkm_pkg::op_t'(in_op);
  assign in_ready  = (state_r == S_IDLE) && (!out_valid_r || out_ready);
  assign in_acc    = in_valid && in_ready;
  assign cfg_ready = 1'b1;
  assign idx_ok    = ((tkm_pkg::SID_W + 1)'(in_stream_index) < (tkm_pkg::SID_W + 1)'(STREAMS));

  assign last      = chain[STREAMS];
  assign scan_done = (state_r == S_SCAN) && last.tok;
  assign give      = last.found && !last.pend;

  always_comb begin
    cmd           = '0;
    cmd.push      = in_acc && (op == tkm_pkg::OP_PUSH) && idx_ok;
    cmd.close     = in_acc && (op == tkm_pkg::OP_CLOSE) && idx_ok;
    cmd.take      = scan_done && give;
    cmd.sid       = cmd.take ? last.sid : tkm_pkg::SID_W'(in_stream_index);
    cmd.rec_time  = in_rec_time;
    cmd.rec_event = in_rec_event;
    cmd.rec_node  = in_rec_node;
    cmd.init_code = init_code_r;
  end

  always_comb begin
    chain[0]     = '0;
    chain[0].tok = in_acc && (op == tkm_pkg::OP_SELECT);
  end

  for (genvar g = 0; g < STREAMS; g++) begin : g_cell
    tkm_cell #(.ID(g)) u_cell (
      .clk      (clk),
      .rst_n    (rst_n),
      .cmd      (cmd),
      .cand_in  (chain[g]),
      .cand_out (chain[g+1])
    );
  end

  for (genvar g = 0; g <= STREAMS; g++) begin : g_tok
    assign tok_vec[g] = chain[g].tok;
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        if (in_acc && op == tkm_pkg::OP_SELECT) begin
          state_nxt = S_SCAN;
        end
      end
      S_SCAN: begin
        if (last.tok) begin
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // base time latches on the first record ever given
  assign base_sel = base_taken_r ? base_time_r : last.rec_time;
  assign time_adj = adjust_r ? (last.rec_time - base_sel) : last.rec_time;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      adjust_r     <= 1'b0;
      init_code_r  <= '0;
      base_time_r  <= '0;
      base_taken_r <= 1'b0;
      out_valid_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (cfg_valid && cfg_ready) begin
        if (cfg_index == tkm_pkg::REG_ADJUST) begin
          adjust_r <= cfg_data[0];
        end else if (cfg_index == tkm_pkg::REG_INIT_CODE) begin
          init_code_r <= cfg_data;
        end
      end
      if (scan_done && give && !base_taken_r) begin
        base_time_r  <= last.rec_time;
        base_taken_r <= 1'b1;
      end
      if ((in_acc && op != tkm_pkg::OP_SELECT) || scan_done) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc && op != tkm_pkg::OP_SELECT) begin
      status_r <= tkm_pkg::ST_ACCEPTED;
      stream_r <= '0;
      time_r   <= '0;
      event_r  <= '0;
      node_r   <= '0;
      wraps_r  <= '0;
    end else if (scan_done) begin
      if (last.pend) begin
        status_r <= tkm_pkg::ST_WAITING;
      end else if (last.found) begin
        status_r <= tkm_pkg::ST_GIVEN;
      end else begin
        status_r <= tkm_pkg::ST_NONE;
      end
      stream_r <= give ? last.sid[tkm_pkg::SIDX_W-1:0] : '0;
      time_r   <= give ? time_adj : '0;
      event_r  <= give ? last.rec_event : '0;
      node_r   <= give ? last.rec_node : '0;
      wraps_r  <= give ? last.wrap : '0;
    end
  end

  assign out_valid  = out_valid_r;
  assign out_status = status_r;
  assign out_stream = stream_r;
  assign out_time   = time_r;
  assign out_event  = event_r;
  assign out_node   = node_r;
  assign out_wraps  = wraps_r;

`ifndef ASSERT_OFF
  a_one_token: assert property (@(posedge clk) disable iff (!rst_n)
    $onehot0(tok_vec))
    else $error("more than one scan token in the cell row");

  a_scan_no_out: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_SCAN) |-> (!out_valid_r && !in_ready))
    else $error("scan overlaps a pending result or an input transaction");

  a_token_only_in_scan: assert property (@(posedge clk) disable iff (!rst_n)
    last.tok |-> (state_r == S_SCAN))
    else $error("scan token left the row outside a scan");

  a_give_result: assert property (@(posedge clk) disable iff (!rst_n)
    (scan_done && give) |=> (out_valid_r && out_status == tkm_pkg::ST_GIVEN))
    else $error("selected record not presented");
`endif

endmodule
